// ===== sv/dtsm_pkg.sv =====
// ----------------------------------------------------------------------------
// dtsm_pkg
// Shared types and constants for the two-queue timestamp merge unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dtsm_pkg;

  // Field widths of the packet payload.
  localparam int STAMP_W  = 64;
  localparam int HANDLE_W = 32;

  // Default number of entries per queue.
  localparam int QUEUE_DEPTH_DEF = 16;

  // Input item kinds.
  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Result item kinds.
  localparam logic RK_STATUS = 1'b0;
  localparam logic RK_PACKET = 1'b1;

  // One queue entry: decode timestamp and payload handle.
  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted input item
    logic push;     // perform the push and load its status result
    logic rd;       // read both queue heads into the head registers
    logic emit;     // pop the winning head and load it as a result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic a_empty;
    logic v_empty;
    logic emit_last;  // the pending pop empties its queue
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/dtsm_if.sv =====
// ----------------------------------------------------------------------------
// dtsm_if
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtsm_in_if import dtsm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic                       is_audio;
  logic signed [STAMP_W-1:0]  stamp;
  logic        [HANDLE_W-1:0] handle;

  modport source (output valid, kind, is_audio, stamp, handle, input ready);
  modport sink   (input valid, kind, is_audio, stamp, handle, output ready);
endinterface

interface dtsm_out_if import dtsm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       result_kind;
  logic                       accepted;
  logic                       from_audio;
  logic signed [STAMP_W-1:0]  out_stamp;
  logic        [HANDLE_W-1:0] out_handle;
  logic                       last;

  modport source (output valid, result_kind, accepted, from_audio, out_stamp,
                  out_handle, last, input ready);
  modport sink   (input valid, result_kind, accepted, from_audio, out_stamp,
                  out_handle, last, output ready);
endinterface

`default_nettype wire

// ===== sv/dtsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtsm_ctrl
// Controller: sequences push and drain operations and owns the result
// register's valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsm_ctrl import dtsm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_kind,
  output logic      in_ready,
  input  wire logic out_ready,
  output logic      out_valid,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PUSH = 2'd1;
  localparam logic [1:0] S_DRD  = 2'd2;
  localparam logic [1:0] S_DCMP = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next-state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_kind == KIND_DRAIN) ? S_DRD : S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DRD: begin
        if (sts.a_empty || sts.v_empty) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_DCMP;
        end
      end
      S_DCMP: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.emit_last ? S_IDLE : S_DRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid: set on load, cleared when the transfer completes.
  always_comb begin
    if (cmd.push || cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A compare-and-emit step always follows a head read.
  a_dcmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DCMP) |-> ($past(state_r) == S_DRD || $past(state_r) == S_DCMP))
    else $error("compare state entered without a head read");

  // A result is never loaded over one that has not been transferred.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push || cmd.emit) |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // The input item is latched only on an input transfer.
  a_capture_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (in_valid && in_ready))
    else $error("input latched without a transfer");

endmodule

`default_nettype wire

// ===== sv/dtsm_dp.sv =====
// ----------------------------------------------------------------------------
// dtsm_dp
// Datapath: the audio and video queue memories, their head and count
// registers, the head compare and the result register payload.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsm_dp import dtsm_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cmd_t                       cmd,
  input  wire logic                       in_is_audio,
  input  wire logic signed [STAMP_W-1:0]  in_stamp,
  input  wire logic        [HANDLE_W-1:0] in_handle,
  output sts_t                            sts,
  output logic                            res_kind,
  output logic                            res_accepted,
  output logic                            res_from_audio,
  output logic signed [STAMP_W-1:0]       res_stamp,
  output logic        [HANDLE_W-1:0]      res_handle,
  output logic                            res_last
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
  localparam logic [SW-1:0] DEPTH_S  = SW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(QUEUE_DEPTH - 1);

  entry_t a_mem [QUEUE_DEPTH];
  entry_t v_mem [QUEUE_DEPTH];

  logic                       is_audio_r;
  logic        [STAMP_W-1:0]  stamp_r;
  logic        [HANDLE_W-1:0] handle_r;
  entry_t                     a_rd_r, v_rd_r;
  logic        [AW-1:0]       a_head_r, a_head_nxt, v_head_r, v_head_nxt;
  logic        [CW-1:0]       a_cnt_r, a_cnt_nxt, v_cnt_r, v_cnt_nxt;
  logic                       a_full, v_full, room, push_ok, pick_audio;
  logic        [SW-1:0]       tail_sum, tail_wrap;
  logic        [AW-1:0]       tail;

  // Latch the accepted input item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_audio_r <= in_is_audio;
      stamp_r    <= in_stamp;
      handle_r   <= in_handle;
    end
  end

  assign a_full  = (a_cnt_r == DEPTH_C);
  assign v_full  = (v_cnt_r == DEPTH_C);
  assign room    = is_audio_r ? !a_full : !v_full;
  assign push_ok = cmd.push && room;

  // Tail position of the target queue: head plus count, wrapped once.
  assign tail_sum  = is_audio_r ? (SW'(a_head_r) + SW'(a_cnt_r))
                                : (SW'(v_head_r) + SW'(v_cnt_r));
  assign tail_wrap = (tail_sum >= DEPTH_S) ? (tail_sum - DEPTH_S) : tail_sum;
  assign tail      = tail_wrap[AW-1:0];

  // Queue memories: one write port at the tail, registered read at the head.
  always_ff @(posedge clk) begin
    if (push_ok && is_audio_r) begin
      a_mem[tail] <= '{stamp: stamp_r, handle: handle_r};
    end
    if (cmd.rd) begin
      a_rd_r <= a_mem[a_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok && !is_audio_r) begin
      v_mem[tail] <= '{stamp: stamp_r, handle: handle_r};
    end
    if (cmd.rd) begin
      v_rd_r <= v_mem[v_head_r];
    end
  end

  // Signed head compare; audio wins ties.
  assign pick_audio = ($signed(a_rd_r.stamp) <= $signed(v_rd_r.stamp));

  assign sts.a_empty   = (a_cnt_r == '0);
  assign sts.v_empty   = (v_cnt_r == '0);
  assign sts.emit_last = pick_audio ? (a_cnt_r == CW'(1)) : (v_cnt_r == CW'(1));

  // Head and count update for push and pop.
  always_comb begin
    a_head_nxt = a_head_r;
    a_cnt_nxt  = a_cnt_r;
    v_head_nxt = v_head_r;
    v_cnt_nxt  = v_cnt_r;
    if (push_ok) begin
      if (is_audio_r) begin
        a_cnt_nxt = a_cnt_r + CW'(1);
      end else begin
        v_cnt_nxt = v_cnt_r + CW'(1);
      end
    end
    if (cmd.emit) begin
      if (pick_audio) begin
        a_head_nxt = (a_head_r == LAST_POS) ? '0 : a_head_r + AW'(1);
        a_cnt_nxt  = a_cnt_r - CW'(1);
      end else begin
        v_head_nxt = (v_head_r == LAST_POS) ? '0 : v_head_r + AW'(1);
        v_cnt_nxt  = v_cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_head_r <= '0;
      a_cnt_r  <= '0;
      v_head_r <= '0;
      v_cnt_r  <= '0;
    end else begin
      a_head_r <= a_head_nxt;
      a_cnt_r  <= a_cnt_nxt;
      v_head_r <= v_head_nxt;
      v_cnt_r  <= v_cnt_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      res_kind       <= RK_STATUS;
      res_accepted   <= room;
      res_from_audio <= 1'b0;
      res_stamp      <= '0;
      res_handle     <= '0;
      res_last       <= 1'b1;
    end else if (cmd.emit) begin
      res_kind       <= RK_PACKET;
      res_accepted   <= 1'b0;
      res_from_audio <= pick_audio;
      res_stamp      <= pick_audio ? a_rd_r.stamp : v_rd_r.stamp;
      res_handle     <= pick_audio ? a_rd_r.handle : v_rd_r.handle;
      res_last       <= sts.emit_last;
    end
  end

  // Counts never exceed the queue depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (a_cnt_r <= DEPTH_C) && (v_cnt_r <= DEPTH_C))
    else $error("queue count above depth");

  // A packet is only emitted while both queues hold entries.
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!sts.a_empty && !sts.v_empty))
    else $error("emit from an empty queue");

  // An audio pop lowers the audio count by one and leaves video alone.
  a_pop_audio: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && pick_audio) |=>
      (a_cnt_r == $past(a_cnt_r) - CW'(1)) && $stable(v_cnt_r))
    else $error("audio pop count mismatch");

endmodule

`default_nettype wire

// ===== sv/dts_ordered_two_queue_merge_unit.sv =====
// ----------------------------------------------------------------------------
// dts_ordered_two_queue_merge_unit
// Two bounded packet queues merged in decode timestamp order.
// ----------------------------------------------------------------------------
// The unit takes one item at a time. After the transfer cycle, a push updates
// its queue and loads the status result, and it
// answers with one status result whether or not the packet fit. A drain
// occupies the transfer cycle, then for each emitted packet a read step to
// check that both queues hold packets and read both queue heads from the
// registered-read queue memories, and a compare step to compare the signed
// timestamps and load the winner. A drain ends when a pop empties its queue,
// and a drain with either queue empty gives no result.
// Audio wins timestamp ties, and the final packet of a drain carries last.
// Each result waits in an output register until taken, and a stall on the
// result channel holds a push or drain until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_ordered_two_queue_merge_unit import dtsm_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dtsm_in_if.sink    in_ch,
  dtsm_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready, out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // Operation sequencing.
  dtsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ready),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Queues, compare and result payload.
  dtsm_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_is_audio    (in_ch.is_audio),
    .in_stamp       (in_ch.stamp),
    .in_handle      (in_ch.handle),
    .sts            (sts),
    .res_kind       (out_ch.result_kind),
    .res_accepted   (out_ch.accepted),
    .res_from_audio (out_ch.from_audio),
    .res_stamp      (out_ch.out_stamp),
    .res_handle     (out_ch.out_handle),
    .res_last       (out_ch.last)
  );

endmodule

`default_nettype wire
